### rtl/cooperative_priority_scheduler_macros.svh
// assertion helpers for the scheduler checker
`ifndef COOPERATIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define COOPERATIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication
`define CPS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("scheduler check failed");

// next-cycle implication
`define CPS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("scheduler check failed");

`endif

### rtl/cps_pkg.sv
package cps_pkg;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_WAITING  = 3'd3,
    ST_MORIBUND = 3'd4
  } slot_state_t;

  localparam int WAIT_W = 7;
  localparam logic [WAIT_W-1:0] WAIT_NONE = '1;
  localparam logic [4:0] BOOT_PRIORITY = 5'd16;
  localparam logic [7:0] SUSPEND_MAX = 8'd255;
  localparam logic [7:0] CREATE_SUSPEND = 8'd1;

  localparam logic [3:0] ACT_CREATE  = 4'd0;
  localparam logic [3:0] ACT_RESUME  = 4'd1;
  localparam logic [3:0] ACT_SUSPEND = 4'd2;
  localparam logic [3:0] ACT_SLEEP   = 4'd3;
  localparam logic [3:0] ACT_WAKEUP  = 4'd4;
  localparam logic [3:0] ACT_YIELD   = 4'd5;
  localparam logic [3:0] ACT_EXIT    = 4'd6;
  localparam logic [3:0] ACT_CANCEL  = 4'd7;
  localparam logic [3:0] ACT_JOIN    = 4'd8;

  typedef struct packed {
    slot_state_t       state;
    logic [4:0]        prio;
    logic [7:0]        susp;
    logic [WAIT_W-1:0] wait_tgt;
  } entry_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_CREATE,
    TGT_RESUME,
    TGT_SUSPEND,
    TGT_CANCEL
  } tgt_op_t;

  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_READY,
    CUR_WAIT,
    CUR_EXIT
  } cur_op_t;

  typedef struct packed {
    tgt_op_t           tgt_op;
    cur_op_t           cur_op;
    logic [WAIT_W-1:0] cur_wait;
    logic              wake_en;
    logic [WAIT_W-1:0] wake_tgt;
    logic [4:0]        create_prio;
  } plan_t;

endpackage

### rtl/cps_table.sv
module cps_table #(
  parameter int THREAD_SLOTS = 8,
  parameter int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [SW-1:0]   raddr,
  output cps_pkg::entry_t rdata,
  input  logic            we,
  input  logic [SW-1:0]   waddr,
  input  cps_pkg::entry_t wdata
);

  cps_pkg::entry_t mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] valid;
  cps_pkg::entry_t rdata_q;
  logic rvalid_q;
  logic [SW-1:0] ridx_q;
  cps_pkg::entry_t boot_entry;
  cps_pkg::entry_t free_entry;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    ridx_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_q <= valid[raddr];
    end
  end

  always_comb begin
    boot_entry.state = cps_pkg::ST_RUNNING;
    boot_entry.prio = cps_pkg::BOOT_PRIORITY;
    boot_entry.susp = '0;
    boot_entry.wait_tgt = cps_pkg::WAIT_NONE;
    free_entry.state = cps_pkg::ST_FREE;
    free_entry.prio = '0;
    free_entry.susp = '0;
    free_entry.wait_tgt = cps_pkg::WAIT_NONE;
  end

  assign rdata = rvalid_q ? rdata_q : ((ridx_q == '0) ? boot_entry : free_entry);

endmodule

### rtl/cps_slot_update.sv
module cps_slot_update (
  input  cps_pkg::entry_t entry_in,
  input  cps_pkg::plan_t  plan,
  input  logic            is_tgt,
  input  logic            is_cur,
  output cps_pkg::entry_t entry_out,
  output logic            eligible
);

  always_comb begin
    entry_out = entry_in;
    if (is_tgt) begin
      unique case (plan.tgt_op)
        cps_pkg::TGT_CREATE: begin
          entry_out.state = cps_pkg::ST_READY;
          entry_out.prio = plan.create_prio;
          entry_out.susp = cps_pkg::CREATE_SUSPEND;
          entry_out.wait_tgt = cps_pkg::WAIT_NONE;
        end
        cps_pkg::TGT_RESUME: begin
          entry_out.susp = entry_in.susp - 8'd1;
        end
        cps_pkg::TGT_SUSPEND: begin
          if (entry_in.susp != cps_pkg::SUSPEND_MAX) begin
            entry_out.susp = entry_in.susp + 8'd1;
          end
        end
        cps_pkg::TGT_CANCEL: begin
          entry_out.state = cps_pkg::ST_MORIBUND;
          entry_out.wait_tgt = cps_pkg::WAIT_NONE;
        end
        default: begin
        end
      endcase
    end
    if (is_cur) begin
      unique case (plan.cur_op)
        cps_pkg::CUR_READY: entry_out.state = cps_pkg::ST_READY;
        cps_pkg::CUR_WAIT: begin
          entry_out.state = cps_pkg::ST_WAITING;
          entry_out.wait_tgt = plan.cur_wait;
        end
        cps_pkg::CUR_EXIT: begin
          entry_out.state = cps_pkg::ST_MORIBUND;
          entry_out.wait_tgt = cps_pkg::WAIT_NONE;
        end
        default: begin
        end
      endcase
    end
    // wake anyone blocked on the target
    if (plan.wake_en && entry_out.state == cps_pkg::ST_WAITING &&
        entry_out.wait_tgt == plan.wake_tgt) begin
      entry_out.state = cps_pkg::ST_READY;
      entry_out.wait_tgt = cps_pkg::WAIT_NONE;
    end
    eligible = (entry_out.state == cps_pkg::ST_READY) && (entry_out.susp == '0);
  end

endmodule

### rtl/cooperative_priority_scheduler.sv
// channel  dir  tdata fields (low bit up)
// s_*      in   action[3:0] thread_slot[6:4] priority_req[11:7] wait_queue[15:12]
// m_*      out  running_thread[2:0] none_running[3] old_suspend_count[11:4] switched[12]
//
// one event at a time; each event is a target read, then one read-modify-write
// sweep of the slot table memory, then up to two state fixups through the
// table's one read port and one write port
// rst is synchronous; slot table entries fall back to reset values via valid bits
// a pending result is held under m_tready low; the next event is still taken
module cooperative_priority_scheduler #(
  parameter int THREAD_SLOTS = 8,
  parameter int WAIT_QUEUES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // action, thread_slot, priority_req, wait_queue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // running_thread, none_running, old_suspend_count, switched
);

  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNTW = $clog2(THREAD_SLOTS + 1);
  localparam int WW = cps_pkg::WAIT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_PASS, S_FIX0, S_FIX1, S_FIX2, S_FIX3, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SCH_NONE, SCH_RESCHED, SCH_YIELD, SCH_TAKE
  } sched_t;

  state_t st;
  logic [3:0] action;
  logic [2:0] slot_in;
  logic [4:0] prio_in;
  logic [3:0] queue_in;
  logic [SW-1:0] cur;
  logic [4:0] cur_prio;
  logic idle;
  logic was_idle;
  logic [SW-1:0] was_cur;
  logic [7:0] old_count;
  logic [7:0] old_count_next;
  cps_pkg::plan_t plan;
  cps_pkg::plan_t plan_next;
  sched_t sched;
  sched_t sched_next;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] wcnt;
  logic [SW-1:0] widx;
  logic bfound;
  logic [SW-1:0] bidx;
  logic [4:0] bprio;
  logic [1:0] fcnt;
  logic [SW-1:0] fa0;
  logic [SW-1:0] fa1;
  cps_pkg::slot_state_t fs0;

  logic s_ok;
  logic q_ok;
  logic [SW-1:0] tslot;
  logic is_self;

  logic [SW-1:0] raddr;
  cps_pkg::entry_t rdata;
  logic we;
  logic [SW-1:0] waddr;
  cps_pkg::entry_t wdata;
  cps_pkg::entry_t upd;
  logic upd_elig;
  logic is_tgt;
  logic is_cur;
  logic switched;
  logic emit;
  logic grab;
  logic swap;

  assign s_tready = (st == S_IDLE);
  assign s_ok = (32'(slot_in) < THREAD_SLOTS);
  assign q_ok = (32'(queue_in) < WAIT_QUEUES);
  assign tslot = SW'(slot_in);
  assign is_self = !idle && s_ok && (tslot == cur);
  assign wcnt = cnt - CNTW'(1);
  assign widx = wcnt[SW-1:0];
  assign is_tgt = (plan.tgt_op != cps_pkg::TGT_NONE) && (widx == tslot);
  assign is_cur = (widx == cur);
  assign switched = (was_idle != idle) || (!idle && cur != was_cur);
  assign emit = (st == S_DONE) && (!m_tvalid || m_tready);
  assign grab = bfound && (sched == SCH_TAKE ||
                           (idle && (sched == SCH_RESCHED || sched == SCH_YIELD)));
  assign swap = bfound && !idle && ((sched == SCH_RESCHED && bprio < cur_prio) ||
                                    (sched == SCH_YIELD && bprio <= cur_prio));

  cps_table #(.THREAD_SLOTS(THREAD_SLOTS), .SW(SW)) u_table (
    .clk(clk), .rst(rst), .raddr(raddr), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  cps_slot_update u_update (
    .entry_in(rdata), .plan(plan), .is_tgt(is_tgt), .is_cur(is_cur),
    .entry_out(upd), .eligible(upd_elig)
  );

  always_comb begin
    priority if (st == S_IDLE) begin
      raddr = SW'(s_tdata[6:4]);
    end else if (st == S_PASS) begin
      raddr = cnt[SW-1:0];
    end else if (st == S_FIX1) begin
      raddr = fa0;
    end else begin
      raddr = fa1;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = widx;
    wdata = upd;
    priority if (st == S_PASS) begin
      we = (cnt != '0);
    end else if (st == S_FIX2) begin
      we = (fcnt != 2'd0);
      waddr = fa0;
      wdata = rdata;
      wdata.state = fs0;
    end else if (st == S_FIX3) begin
      we = (fcnt == 2'd2);
      waddr = fa1;
      wdata = rdata;
      wdata.state = cps_pkg::ST_RUNNING;
    end
  end

  // decode the event against the target slot entry
  always_comb begin
    plan_next.tgt_op = cps_pkg::TGT_NONE;
    plan_next.cur_op = cps_pkg::CUR_NONE;
    plan_next.cur_wait = cps_pkg::WAIT_NONE;
    plan_next.wake_en = 1'b0;
    plan_next.wake_tgt = cps_pkg::WAIT_NONE;
    plan_next.create_prio = prio_in;
    sched_next = SCH_NONE;
    old_count_next = '0;
    unique case (action)
      cps_pkg::ACT_CREATE: begin
        if (s_ok && (rdata.state == cps_pkg::ST_FREE ||
                     rdata.state == cps_pkg::ST_MORIBUND)) begin
          plan_next.tgt_op = cps_pkg::TGT_CREATE;
        end
      end
      cps_pkg::ACT_RESUME: begin
        if (s_ok) begin
          old_count_next = rdata.susp;
          if (rdata.susp != '0) begin
            plan_next.tgt_op = cps_pkg::TGT_RESUME;
            if (rdata.susp == 8'd1) begin
              sched_next = SCH_RESCHED;
            end
          end
        end
      end
      cps_pkg::ACT_SUSPEND: begin
        if (s_ok) begin
          old_count_next = rdata.susp;
          plan_next.tgt_op = cps_pkg::TGT_SUSPEND;
          if (is_self) begin
            plan_next.cur_op = cps_pkg::CUR_READY;
            sched_next = SCH_TAKE;
          end
        end
      end
      cps_pkg::ACT_SLEEP: begin
        if (q_ok) begin
          if (idle) begin
            sched_next = SCH_RESCHED;
          end else begin
            plan_next.cur_op = cps_pkg::CUR_WAIT;
            plan_next.cur_wait = WW'(queue_in);
            sched_next = SCH_TAKE;
          end
        end
      end
      cps_pkg::ACT_WAKEUP: begin
        if (q_ok) begin
          plan_next.wake_en = 1'b1;
          plan_next.wake_tgt = WW'(queue_in);
          sched_next = SCH_RESCHED;
        end
      end
      cps_pkg::ACT_YIELD: sched_next = SCH_YIELD;
      cps_pkg::ACT_EXIT: begin
        if (idle) begin
          sched_next = SCH_RESCHED;
        end else begin
          plan_next.cur_op = cps_pkg::CUR_EXIT;
          plan_next.wake_en = 1'b1;
          plan_next.wake_tgt = WW'(WAIT_QUEUES) + WW'(cur);
          sched_next = SCH_TAKE;
        end
      end
      cps_pkg::ACT_CANCEL: begin
        if (s_ok && rdata.state != cps_pkg::ST_FREE) begin
          plan_next.wake_en = 1'b1;
          if (is_self) begin
            plan_next.cur_op = cps_pkg::CUR_EXIT;
            plan_next.wake_tgt = WW'(WAIT_QUEUES) + WW'(cur);
            sched_next = SCH_TAKE;
          end else begin
            plan_next.tgt_op = cps_pkg::TGT_CANCEL;
            plan_next.wake_tgt = WW'(WAIT_QUEUES) + WW'(tslot);
            sched_next = SCH_RESCHED;
          end
        end
      end
      cps_pkg::ACT_JOIN: begin
        if (s_ok) begin
          if (idle) begin
            sched_next = SCH_RESCHED;
          end else if (tslot != cur && rdata.state != cps_pkg::ST_FREE &&
                       rdata.state != cps_pkg::ST_MORIBUND) begin
            plan_next.cur_op = cps_pkg::CUR_WAIT;
            plan_next.cur_wait = WW'(WAIT_QUEUES) + WW'(tslot);
            sched_next = SCH_TAKE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      m_tvalid <= 1'b0;
      cur <= '0;
      idle <= 1'b0;
      cur_prio <= cps_pkg::BOOT_PRIORITY;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            action <= s_tdata[3:0];
            slot_in <= s_tdata[6:4];
            prio_in <= s_tdata[11:7];
            queue_in <= s_tdata[15:12];
            was_idle <= idle;
            was_cur <= cur;
            st <= S_DEC;
          end
        end
        S_DEC: begin
          plan <= plan_next;
          sched <= sched_next;
          old_count <= old_count_next;
          cnt <= '0;
          bfound <= 1'b0;
          st <= S_PASS;
        end
        S_PASS: begin
          if (cnt != '0 && upd_elig && (!bfound || upd.prio < bprio)) begin
            bfound <= 1'b1;
            bidx <= widx;
            bprio <= upd.prio;
          end
          if (cnt == CNTW'(THREAD_SLOTS)) begin
            st <= S_FIX0;
          end
          cnt <= cnt + CNTW'(1);
        end
        S_FIX0: begin
          fa1 <= bidx;
          if (swap) begin
            fcnt <= 2'd2;
            fa0 <= cur;
            fs0 <= cps_pkg::ST_READY;
            cur <= bidx;
            cur_prio <= bprio;
          end else if (grab) begin
            fcnt <= 2'd1;
            fa0 <= bidx;
            fs0 <= cps_pkg::ST_RUNNING;
            cur <= bidx;
            cur_prio <= bprio;
            idle <= 1'b0;
          end else begin
            fcnt <= 2'd0;
            if (sched == SCH_TAKE) begin
              idle <= 1'b1;
            end
          end
          st <= S_FIX1;
        end
        S_FIX1: st <= S_FIX2;
        S_FIX2: st <= S_FIX3;
        S_FIX3: st <= S_DONE;
        S_DONE: begin
          if (emit) begin
            m_tdata <= {3'b000, switched, old_count, idle,
                        idle ? 3'd0 : 3'(cur)};
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/cps_checker.sv
`include "cooperative_priority_scheduler_macros.svh"

module cps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  `CPS_ASSERT_NOW(idle_reports_slot_zero, clk, rst, m_tvalid && m_tdata[3], m_tdata[2:0] == 3'd0)
  `CPS_ASSERT_NEXT(busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `CPS_ASSERT_NEXT(result_held, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind cooperative_priority_scheduler cps_checker u_cps_checker (.*);
